// ----- rtl/mtrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mtrs_pkg
// Types, constants and helpers shared by the member table blocks.
// ----------------------------------------------------------------------------
package mtrs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SAMPLE_MAX  = 8;
  localparam int ADDR_BYTES  = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W      = $clog2(SAMPLE_MAX);
  localparam int K_W         = $clog2(SAMPLE_MAX + 1);
  localparam int MOD_STEPS   = 32;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } stat_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] member_id;
    logic [15:0] member_version;
    logic [3:0]  addr_length;
    logic [63:0] addr_bytes;
    logic [3:0]  sample_count;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] out_id;
    logic [15:0] out_version;
    logic [3:0]  out_addr_length;
    logic [63:0] out_addr;
    logic [3:0]  sample_total;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] version;
    logic [3:0]  alen;
    logic [63:0] addr;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SMP_DRAW,
    ST_SMP_DIV,
    ST_SMP_RD,
    ST_SMP_EMIT
  } state_e;

  function automatic logic [3:0] len_clamp(input logic [3:0] len);
    return (len > 4'(ADDR_BYTES)) ? 4'(ADDR_BYTES) : len;
  endfunction

  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < ADDR_BYTES; b++) begin
      m[8*b +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    logic [31:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

// ----- rtl/mtrs_table_ram.sv -----
// ----------------------------------------------------------------------------
// mtrs_table_ram
// Member table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mtrs_table_ram (
  input  logic             clk,
  input  mtrs_pkg::mem_req_t req,
  output mtrs_pkg::entry_t rd_data
);
  import mtrs_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    // read data holds when no read is issued
    if (req.re) rd_data <= mem[req.raddr];
  end

endmodule

// ----- rtl/mtrs_mod.sv -----
// ----------------------------------------------------------------------------
// mtrs_mod
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtrs_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               dividend,
  input  logic [mtrs_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [mtrs_pkg::IDX_W-1:0] rem
);
  import mtrs_pkg::*;

  logic                 run;
  logic [MOD_CNT_W-1:0] cnt;
  logic [31:0]          quo;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       trial_sub;

  assign trial     = {rem_r, quo[31]};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem_r <= '0;
      dvs   <= divisor;
    end else if (run) begin
      quo <= quo << 1;
      if (trial >= {1'b0, dvs}) rem_r <= trial_sub[CNT_W-1:0];
      else rem_r <= trial[CNT_W-1:0];
    end
  end

  // remainder is below the divisor, at most TABLE_DEPTH - 1
  assign rem = rem_r[IDX_W-1:0];

endmodule

// ----- rtl/member_table_with_reservoir_sample.sv -----
// Put/remove/find scan stored entries in order until a match, reading then comparing each;
//   a remove then moves each later entry down one place, reading and then writing each.
// Sample: each reservoir draw runs the 32-step remainder unit; each result is read, then emitted.
// One command at a time; the next is taken once the command, shifts included, is done.
// Synchronous reset empties the table and loads the LFSR with 1; no clearing pass.
// ----------------------------------------------------------------------------
// member_table_with_reservoir_sample
// Compacted member table with put, remove, find and reservoir sampling.
// ----------------------------------------------------------------------------
module member_table_with_reservoir_sample (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  mtrs_pkg::cmd_item_t  cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mtrs_pkg::result_t    res,
  input  logic                 seed_valid,
  output logic                 seed_ready,
  input  logic [31:0]          seed
);
  import mtrs_pkg::*;

  state_e            state, state_next;
  cmd_item_t         cur;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  j;
  logic [IDX_W-1:0]  hit_idx;
  logic              found;
  logic [K_W-1:0]    k;
  logic [SLOT_W-1:0] si;
  logic [IDX_W-1:0]  slot [SAMPLE_MAX];
  logic [31:0]       lfsr;

  mem_req_t          mreq;
  entry_t            rd_data;
  logic              div_start;
  logic              div_done;
  logic [IDX_W-1:0]  div_rem;

  logic              accept;
  logic              ofree;
  logic              out_load;
  result_t           out_data;
  logic              match;
  logic [CNT_W-1:0]  k_wide;
  logic [K_W-1:0]    k_next;
  logic              full;
  logic              si_last;
  logic [CNT_W-1:0]  idx_dec;

  mtrs_table_ram u_ram (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  mtrs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lfsr_step(lfsr)),
    .divisor  (j + 1'b1),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign seed_ready = 1'b1;
  assign cmd_stall  = (state != ST_IDLE);
  assign accept     = cmd_valid && !cmd_stall;
  assign ofree      = !res_valid || !res_stall;
  assign full       = (count == CNT_W'(TABLE_DEPTH));
  assign si_last    = ({1'b0, si} + 1'b1) == k;
  assign idx_dec    = idx - 1'b1;

  always_comb begin
    k_wide = CNT_W'(cmd.sample_count);
    if (k_wide > count) k_wide = count;
    if (k_wide > CNT_W'(SAMPLE_MAX)) k_wide = CNT_W'(SAMPLE_MAX);
    k_next = k_wide[K_W-1:0];
  end

  always_comb begin
    if (cur.command == CMD_FIND) begin
      match = (rd_data.addr & len_mask(cur.addr_length)) == cur.addr_bytes;
    end else begin
      match = (rd_data.id == cur.member_id) && (rd_data.version == cur.member_version) &&
              (rd_data.alen == cur.addr_length) && (rd_data.addr == cur.addr_bytes);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.command != CMD_SAMPLE) state_next = ST_SCAN_RD;
          else if (k_next == '0) state_next = ST_EMIT;
          else state_next = ST_SMP_DRAW;
        end
      end
      ST_SCAN_RD:  state_next = (idx == count) ? ST_EMIT : ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = match ? ST_EMIT : ST_SCAN_RD;
      ST_EMIT: begin
        if (ofree) begin
          if (cur.command == CMD_REMOVE && found) state_next = ST_SHIFT_RD;
          else state_next = ST_IDLE;
        end
      end
      ST_SHIFT_RD: state_next = (idx >= count) ? ST_IDLE : ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_SMP_DRAW: state_next = (j >= count) ? ST_SMP_RD : ST_SMP_DIV;
      ST_SMP_DIV:  state_next = div_done ? ST_SMP_DRAW : ST_SMP_DIV;
      ST_SMP_RD:   state_next = ST_SMP_EMIT;
      ST_SMP_EMIT: begin
        if (ofree) state_next = si_last ? ST_IDLE : ST_SMP_RD;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs: memory requests, divider start, result beat
  always_comb begin
    mreq      = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    out_data  = '0;
    out_data.last = 1'b1;
    case (state)
      ST_SCAN_RD: begin
        mreq.re    = (idx != count);
        mreq.raddr = idx[IDX_W-1:0];
      end
      ST_EMIT: begin
        out_load = ofree;
        if (found) begin
          out_data.status          = STAT_OK;
          out_data.entry_index     = hit_idx;
          out_data.out_id          = rd_data.id;
          out_data.out_version     = rd_data.version;
          out_data.out_addr_length = rd_data.alen;
          out_data.out_addr        = rd_data.addr;
        end else if (cur.command == CMD_PUT) begin
          if (full) begin
            out_data.status = STAT_FULL;
          end else begin
            out_data.status          = STAT_OK;
            out_data.entry_index     = count[IDX_W-1:0];
            out_data.out_id          = cur.member_id;
            out_data.out_version     = cur.member_version;
            out_data.out_addr_length = cur.addr_length;
            out_data.out_addr        = cur.addr_bytes;
            mreq.we                  = ofree;
            mreq.waddr               = count[IDX_W-1:0];
            mreq.wdata               = '{cur.member_id, cur.member_version,
                                         cur.addr_length, cur.addr_bytes};
          end
        end else begin
          out_data.status = STAT_NOT_FOUND;
        end
      end
      ST_SHIFT_RD: begin
        mreq.re    = (idx < count);
        mreq.raddr = idx[IDX_W-1:0];
      end
      ST_SHIFT_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx_dec[IDX_W-1:0];
        mreq.wdata = rd_data;
      end
      ST_SMP_DRAW: div_start = (j < count);
      ST_SMP_RD: begin
        mreq.re    = 1'b1;
        mreq.raddr = slot[si];
      end
      ST_SMP_EMIT: begin
        out_load                 = ofree;
        out_data.status          = STAT_OK;
        out_data.entry_index     = slot[si];
        out_data.out_id          = rd_data.id;
        out_data.out_version     = rd_data.version;
        out_data.out_addr_length = rd_data.alen;
        out_data.out_addr        = rd_data.addr;
        out_data.sample_total    = k;
        out_data.last            = si_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      lfsr      <= 32'd1;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (seed_valid && seed_ready) lfsr <= (seed == '0) ? 32'd1 : seed;
      else if (div_start) lfsr <= lfsr_step(lfsr);
      if (mreq.we && state == ST_EMIT) count <= count + 1'b1;
      else if (state == ST_SHIFT_RD && idx >= count) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) res <= out_data;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur   <= '{cmd.command, cmd.member_id, cmd.member_version,
                     len_clamp(cmd.addr_length),
                     cmd.addr_bytes & len_mask(len_clamp(cmd.addr_length)),
                     cmd.sample_count};
          idx   <= '0;
          found <= 1'b0;
          k     <= k_next;
          j     <= CNT_W'(k_next);
          si    <= '0;
          for (int i = 0; i < SAMPLE_MAX; i++) slot[i] <= IDX_W'(i);
        end
      end
      ST_SCAN_CMP: begin
        if (match) begin
          found   <= 1'b1;
          hit_idx <= idx[IDX_W-1:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
      ST_EMIT:     idx <= CNT_W'(hit_idx) + 1'b1;
      ST_SHIFT_WR: idx <= idx + 1'b1;
      ST_SMP_DIV: begin
        if (div_done) begin
          // slot r takes the current index when r falls inside the reservoir
          if (CNT_W'(div_rem) < CNT_W'(k)) slot[div_rem[SLOT_W-1:0]] <= j[IDX_W-1:0];
          j <= j + 1'b1;
        end
      end
      ST_SMP_EMIT: begin
        if (ofree && !si_last) si <= si + 1'b1;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("member count beyond table depth");

  a_multi_is_sample: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> (res.sample_total != '0))
    else $error("non-final beat outside a sample");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SMP_EMIT) |-> ({1'b0, si} < k))
    else $error("sample slot index past reservoir size");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !ofree) |=> (state == ST_EMIT))
    else $error("result dropped while output stalled");

endmodule
